// ----- hdl/mec_pkg.sv -----
// Shared types and constants of the Mandelbrot escape-count core.
package mec_pkg;

  localparam int unsigned FracBitsDef = 28;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned ProdW       = 2 * CoordW;
  localparam int unsigned CountW      = 16;

  localparam logic [CountW-1:0] MaxIterRst = 16'd255;

  typedef enum logic [1:0] {
    MulSqRe,
    MulSqIm,
    MulCross
  } mul_sel_e;

  typedef enum logic [2:0] {
    StIdle,
    StSqRe,
    StSqIm,
    StCross,
    StUpdate,
    StFinish
  } state_e;

  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     update;
  } ctl_t;

  typedef struct packed {
    logic go_on;
  } stat_t;

endpackage

// ----- hdl/mec_dpath.sv -----
// Datapath: iterate registers, one shared signed multiplier, radius test and counter.
module mec_dpath import mec_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctl_t                     ctl_i,
  input  logic [CountW-1:0]        max_iter_i,
  input  logic signed [CoordW-1:0] c_real_i,
  input  logic signed [CoordW-1:0] c_imag_i,
  output stat_t                    stat_o,
  output logic [CountW-1:0]        count_o
);

  localparam int unsigned RadiusExp = 2 * FracBits + 2;
  // When four does not fit the product width, every point is inside.
  localparam logic [ProdW-1:0] RadiusLimit =
    (RadiusExp < ProdW) ? (ProdW'(1) << RadiusExp) : {ProdW{1'b1}};

  logic signed [CoordW-1:0] cr_q, ci_q, re_q, im_q;
  logic signed [ProdW-1:0]  rr_q, ii_q, cross_q;
  logic [CountW-1:0]        count_q;

  logic signed [CoordW-1:0] op_a, op_b;
  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  diff, diff_sh, cross_sh;
  logic signed [CoordW-1:0] re_nxt, im_nxt;
  logic [ProdW-1:0]         mag;

  // The one multiplier; its operands follow the step of the iteration.
  always_comb begin
    case (ctl_i.mul_sel)
      MulSqRe: begin
        op_a = re_q;
        op_b = re_q;
      end
      MulSqIm: begin
        op_a = im_q;
        op_b = im_q;
      end
      MulCross: begin
        op_a = re_q;
        op_b = im_q;
      end
      default: begin
        op_a = re_q;
        op_b = im_q;
      end
    endcase
  end

  assign prod = op_a * op_b;

  // Next iterate: floor shifts are arithmetic shifts, sums wrap to 32 bits.
  assign diff     = rr_q - ii_q;
  assign diff_sh  = diff >>> FracBits;
  assign cross_sh = cross_q >>> (FracBits - 1);
  assign re_nxt   = diff_sh[CoordW-1:0] + cr_q;
  assign im_nxt   = cross_sh[CoordW-1:0] + ci_q;

  // Both squares are non-negative and at most 2^62, so the sum cannot overflow.
  assign mag          = $unsigned(rr_q) + $unsigned(ii_q);
  assign stat_o.go_on = (mag <= RadiusLimit) && (count_q < max_iter_i);
  assign count_o      = count_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cr_q <= c_real_i;
      ci_q <= c_imag_i;
      re_q <= c_real_i;
      im_q <= c_imag_i;
    end else if (ctl_i.update) begin
      re_q <= re_nxt;
      im_q <= im_nxt;
    end
    if (ctl_i.mul_en) begin
      case (ctl_i.mul_sel)
        MulSqRe:  rr_q    <= prod;
        MulSqIm:  ii_q    <= prod;
        MulCross: cross_q <= prod;
        default:  cross_q <= prod;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctl_i.load) begin
      count_q <= '0;
    end else if (ctl_i.update) begin
      count_q <= count_q + CountW'(1);
    end
  end

`ifndef ASSERT_OFF
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.update && !ctl_i.load |=> count_q == $past(count_q) + CountW'(1))
    else $error("iteration count did not advance by one on update");
`endif

endmodule

// ----- hdl/mec_ctrl.sv -----
// Sequencer that steps the shared multiplier through one iteration at a time.
module mec_ctrl import mec_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  out_free_i,
  input  stat_t stat_i,
  output logic  in_ready_o,
  output logic  out_load_o,
  output ctl_t  ctl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_valid_i) state_d = StSqRe;
      StSqRe:   state_d = StSqIm;
      StSqIm:   state_d = StCross;
      StCross:  state_d = stat_i.go_on ? StUpdate : StFinish;
      StUpdate: state_d = StSqRe;
      StFinish: if (out_free_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    out_load_o    = 1'b0;
    ctl_o.load    = 1'b0;
    ctl_o.mul_en  = 1'b0;
    ctl_o.mul_sel = MulSqRe;
    ctl_o.update  = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        ctl_o.load = in_valid_i;
      end
      StSqRe: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MulSqRe;
      end
      StSqIm: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MulSqIm;
      end
      StCross: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MulCross;
      end
      StUpdate: begin
        ctl_o.update = 1'b1;
      end
      StFinish: begin
        out_load_o = out_free_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == StSqRe)
    else $error("accepted item did not start the squaring step");
  a_update_after_test: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StCross && stat_i.go_on |=> ctl_o.update)
    else $error("passed radius test was not followed by an update");
`endif

endmodule

// ----- hdl/mandelbrot_escape_count_core.sv -----
// Top level of the Mandelbrot escape-count core: config register, sequencer, datapath, output.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------------------
//   input    | in_valid_i / in_ready_o   | c_real_i, c_imag_i (signed Q4.28)
//   output   | out_valid_o / out_ready_i | escape_count_o (16-bit count)
//   config   | cfg_we_i (no wait)        | cfg_wdata_i = max_iterations
//
// One shared 32x32 signed multiplier forms re*re, im*im and re*im in the states
// SqRe, SqIm and Cross; while the radius test passes, the Update state then writes
// the next iterate and bumps the count. An item is taken only in the idle state,
// so the next item waits until the last one has left the iteration loop.
// Reset is asynchronous and active low; max_iterations comes up as 255.
// The result sits in an output register, so a new item is taken while it
// waits; the sequencer stalls at the end of an item only if that register
// is still full and not being drained.
module mandelbrot_escape_count_core import mec_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CountW-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] c_real_i,
  input  logic signed [CoordW-1:0] c_imag_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CountW-1:0]        escape_count_o
);

  logic [CountW-1:0] max_iter_q;
  logic              out_valid_q, out_valid_d;
  logic [CountW-1:0] escape_count_q;
  logic [CountW-1:0] count;
  logic              out_free, out_load;
  ctl_t              ctl;
  stat_t             stat;

  // The user must rewrite the bound only while the core is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q <= MaxIterRst;
    end else if (cfg_we_i) begin
      max_iter_q <= cfg_wdata_i;
    end
  end

  mec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .stat_i     (stat),
    .in_ready_o (in_ready_o),
    .out_load_o (out_load),
    .ctl_o      (ctl)
  );

  mec_dpath #(
    .FracBits (FracBits)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .max_iter_i (max_iter_q),
    .c_real_i   (c_real_i),
    .c_imag_i   (c_imag_i),
    .stat_o     (stat),
    .count_o    (count)
  );

  // The output register can take a new count when it is empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      escape_count_q <= count;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign escape_count_o = escape_count_q;

`ifndef ASSERT_OFF
  a_count_in_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> escape_count_o <= max_iter_q)
    else $error("escape count exceeds the configured bound");
`endif

endmodule
